// File: hdl/abb_pkg.sv
// Shared types and constants for the alpha blend blitter.
// No dependencies; compiled first.
package abb_pkg;

    localparam int PIX_W = 32;
    localparam int MUL_B_W = 9;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_BLEND = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 2'd3;

    localparam logic [PIX_W-1:0] MASK_AG   = 32'hFF00FF00;
    localparam logic [PIX_W-1:0] MASK_RB   = 32'h00FF00FF;
    localparam logic [PIX_W-1:0] MASK_G    = 32'h0000FF00;
    localparam logic [PIX_W-1:0] ALPHA_ONE = 32'h01000000;

    typedef struct packed {
        logic               en;
        logic [PIX_W-1:0]   a;
        logic [MUL_B_W-1:0] b;
        logic [PIX_W-1:0]   c;
    } mac_ctl_t;

endpackage

// File: hdl/abb_if.sv
// Handshake channels for the blitter: command words in, result words out.
// Depends on abb_pkg.
interface abb_cmd_if;
    import abb_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [PIX_W-1:0] pixel;
    logic [7:0]       col;
    logic [7:0]       row;

    modport source (output valid, output opcode, output pixel, output col, output row,
                    input ready);
    modport sink (input valid, input opcode, input pixel, input col, input row,
                  output ready);
endinterface

interface abb_rsp_if;
    import abb_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] read_pixel;
    logic             clipped;

    modport source (output valid, output read_pixel, output clipped, input ready);
    modport sink (input valid, input read_pixel, input clipped, output ready);
endinterface

// File: hdl/abb_store.sv
// Frame store: one write port, one read port with registered read data.
// Depends on abb_pkg.
module abb_store #(
    parameter int DEPTH = 65536,
    parameter int AW = 16
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [abb_pkg::PIX_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic [abb_pkg::PIX_W-1:0] rdata
);
    import abb_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/abb_mac.sv
// Shared multiply-add unit: acc <= a * b + c, mod 2^32, one step per cycle while ctl.en is high.
// Depends on abb_pkg.
module abb_mac (
    input  logic                      clk,
    input  abb_pkg::mac_ctl_t         ctl,
    output logic [abb_pkg::PIX_W-1:0] acc
);
    import abb_pkg::*;

    logic [PIX_W-1:0] acc_reg;
    logic [PIX_W-1:0] acc_next;

    assign acc_next = ctl.a * PIX_W'(ctl.b) + ctl.c;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: hdl/alpha_blend_blitter.sv
// Alpha blend blitter top level: config registers, sequencer, shared MAC and frame store.
// Depends on abb_pkg, abb_if, abb_mac, abb_store.
//
// After reset all MAX_WIDTH*MAX_HEIGHT store words are swept to zero and no command
// word is taken meanwhile; config writes are taken at any time. Commands then run one at a
// time on a single 32x9 multiply-add unit and a one-read, one-write store: a blend runs
// address multiply, store read, four multiply-add steps, write-back and result; a read
// address multiply, store read and result; a clipped or unused command only the result;
// a clear the w*h multiply, w*h store writes at one per cycle, then the result. A finished
// result sits in an output register, so the next command may be taken while it waits.
module alpha_blend_blitter #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    abb_cmd_if.sink                       cmd,
    abb_rsp_if.source                     rsp,
    input  logic                          cfg_wr_en,
    input  logic [abb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abb_pkg::CFG_W-1:0]     cfg_data
);
    import abb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WCAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ADDR  = 4'd2;
    localparam logic [3:0] S_SWEEP = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_RB1   = 4'd5;
    localparam logic [3:0] S_RB2   = 4'd6;
    localparam logic [3:0] S_AG1   = 4'd7;
    localparam logic [3:0] S_AG2   = 4'd8;
    localparam logic [3:0] S_WB    = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [8:0]       dest_width_reg;
    logic [8:0]       dest_height_reg;
    logic [10:0]      x_offset_reg;
    logic [10:0]      y_offset_reg;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [1:0]       op_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [10:0]      xq_reg, yq_reg;
    logic [AW-1:0]    addr_reg;
    logic [PIX_W-1:0] res_reg, res_next;
    logic             clip_reg, clip_next;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_clip_reg;

    logic [8:0]       w_eff, h_eff;
    logic [11:0]      xp, yp;
    logic             blend_clip, read_clip;
    logic             accept, out_free;
    logic [7:0]       alpha, nalpha;
    logic [PIX_W-1:0] acc, q, wb_pix;
    mac_ctl_t         mac_ctl;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    assign w_eff = (dest_width_reg > 9'(WCAP)) ? 9'(WCAP) : dest_width_reg;
    assign h_eff = (dest_height_reg > 9'(HCAP)) ? 9'(HCAP) : dest_height_reg;

    assign xp = $signed({4'b0, cmd.col}) + $signed({x_offset_reg[10], x_offset_reg});
    assign yp = $signed({4'b0, cmd.row}) + $signed({y_offset_reg[10], y_offset_reg});
    assign blend_clip = xp[11] || yp[11] || (xp[10:0] >= {2'b0, w_eff})
                        || (yp[10:0] >= {2'b0, h_eff});
    assign read_clip = ({1'b0, cmd.col} >= w_eff) || ({1'b0, cmd.row} >= h_eff);

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign alpha = pix_reg[31:24];
    assign nalpha = ~alpha;
    assign wb_pix = res_reg | (acc & MASK_AG);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg  <= 9'd256;
            dest_height_reg <= 9'd256;
            x_offset_reg    <= '0;
            y_offset_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DEST_WIDTH:  dest_width_reg  <= cfg_data[8:0];
                REG_DEST_HEIGHT: dest_height_reg <= cfg_data[8:0];
                REG_X_OFFSET:    x_offset_reg    <= cfg_data;
                REG_Y_OFFSET:    y_offset_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // MAC operand select
    always_comb
    begin
        mac_ctl = '{en: 1'b0, a: '0, b: '0, c: '0};
        unique case (state_reg)
            S_ADDR:
            begin
                mac_ctl.en = 1'b1;
                mac_ctl.b  = w_eff;
                if (op_reg == OP_CLEAR)
                begin
                    mac_ctl.a = PIX_W'(h_eff);
                end
                else
                begin
                    mac_ctl.a = PIX_W'(yq_reg);
                    mac_ctl.c = PIX_W'(xq_reg);
                end
            end
            S_RB1:
            begin
                mac_ctl.en = (op_reg == OP_BLEND);
                mac_ctl.a  = q & MASK_RB;
                mac_ctl.b  = {1'b0, nalpha};
            end
            S_RB2:
            begin
                mac_ctl.en = 1'b1;
                mac_ctl.a  = pix_reg & MASK_RB;
                mac_ctl.b  = {1'b0, alpha};
                mac_ctl.c  = acc;
            end
            S_AG1:
            begin
                mac_ctl.en = 1'b1;
                mac_ctl.a  = (q & MASK_AG) >> 8;
                mac_ctl.b  = {1'b0, nalpha};
            end
            S_AG2:
            begin
                mac_ctl.en = 1'b1;
                mac_ctl.a  = ALPHA_ONE | ((pix_reg & MASK_G) >> 8);
                mac_ctl.b  = {1'b0, alpha};
                mac_ctl.c  = acc;
            end
            default: ;
        endcase
    end

    // sequencer and store control
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        clip_next  = clip_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = cnt_reg[AW-1:0];
        mem_wdata  = '0;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (cnt_reg == CW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    priority if (cmd.opcode == OP_BLEND)
                    begin
                        clip_next  = blend_clip;
                        state_next = blend_clip ? S_DONE : S_ADDR;
                    end
                    else if (cmd.opcode == OP_READ)
                    begin
                        clip_next  = read_clip;
                        state_next = read_clip ? S_DONE : S_ADDR;
                    end
                    else if (cmd.opcode == OP_CLEAR)
                    begin
                        clip_next  = 1'b0;
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        clip_next  = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_ADDR:
            begin
                state_next = (op_reg == OP_CLEAR) ? S_SWEEP : S_RD;
            end
            S_SWEEP:
            begin
                mem_wdata = pix_reg;
                if (cnt_reg != acc[CW-1:0])
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_RB1;
            end
            S_RB1:
            begin
                if (op_reg == OP_READ)
                begin
                    res_next   = q;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RB2;
                end
            end
            S_RB2:
            begin
                state_next = S_AG1;
            end
            S_AG1:
            begin
                res_next   = (acc >> 8) & MASK_RB;
                state_next = S_AG2;
            end
            S_AG2:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr_reg;
                mem_wdata  = wb_pix;
                res_next   = wb_pix;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            clip_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clip_reg  <= clip_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            op_reg  <= cmd.opcode;
            pix_reg <= cmd.pixel;
            if (cmd.opcode == OP_BLEND)
            begin
                xq_reg <= xp[10:0];
                yq_reg <= yp[10:0];
            end
            else
            begin
                xq_reg <= {3'b0, cmd.col};
                yq_reg <= {3'b0, cmd.row};
            end
        end
        if (state_reg == S_RD)
        begin
            addr_reg <= acc[AW-1:0];
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_pixel_reg <= res_reg;
            out_clip_reg  <= clip_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_pixel = out_pixel_reg;
    assign rsp.clipped    = out_clip_reg;

    abb_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .acc (acc)
    );

    abb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (acc[AW-1:0]),
        .rdata (q)
    );

`ifndef ASSERT_OFF
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !mem_we)
        else $error("store write outside a command");

    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store read and write in one cycle");

    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.clipped) |-> (rsp.read_pixel == '0))
        else $error("clipped word carries a pixel");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer idle after accepting a word");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (cnt_reg <= acc[CW-1:0]))
        else $error("clear sweep overran");
`endif

endmodule
